@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sti_pkg.sv @@
// Shared constants of the segment/triangle intersection block.
package sti_pkg;

    localparam int COORD_BITS = 21;
    localparam int WORD_BITS  = 63;
    localparam int THR_BITS   = 20;
    localparam logic [THR_BITS-1:0] THR_RESET = 20'd1;

endpackage

@@ sv/sti_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
module sti_div #(
    parameter int RW = 93,
    parameter int QB = 22
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] num,
    input  logic [RW-1:0] den,
    output logic [QB-1:0] quo
);

    logic [RW-1:0] rem_reg [QB-1];
    logic [RW-1:0] den_reg [QB-1];
    logic [QB-1:0] q_reg   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [RW-1:0] den_in;
        logic [QB-1:0] q_in;
        logic [RW-1:0] shifted;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign shifted = den_in << (QB - 1 - k);
        assign ge      = (rem_in >= shifted);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= q_in | (QB'(ge) << (QB - 1 - k));
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_in - shifted) : rem_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = q_reg[QB-1];

endmodule

@@ sv/segment_triangle_intersect.sv @@
// Top level of the pipelined segment/triangle intersection test.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: segment start and
//   end plus three triangle vertices, each a packed signed fixed-point
//   3-vector (x low, then y, then z, COORD_BITS per coordinate).
//   Output channel (out_valid / out_stall) returns one item per input item:
//   hit and the packed intersection point (zero on a miss).
//   Config channel (cfg_valid / cfg_ready) writes det_threshold; cfg_ready is
//   always high. Write it only while no item is in flight.
//   Pipeline: twelve arithmetic stages, one divider stage per
//   quotient bit, one output register.
//   Throughput: one item per cycle while no stall holds; all stages advance together.
//   Stall: when the output holds an item that is stalled, every stage holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset: clears all valid bits and loads det_threshold with 1.
module segment_triangle_intersect #(
    parameter int COORD_BITS = sti_pkg::COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sti_pkg::WORD_BITS-1:0]  seg_start,
    input  logic [sti_pkg::WORD_BITS-1:0]  seg_end,
    input  logic [sti_pkg::WORD_BITS-1:0]  vert_a,
    input  logic [sti_pkg::WORD_BITS-1:0]  vert_b,
    input  logic [sti_pkg::WORD_BITS-1:0]  vert_c,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic [sti_pkg::WORD_BITS-1:0]  hit_point,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sti_pkg::THR_BITS-1:0]   det_threshold
);

    `include "assert_macros.svh"

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;               // coordinate difference
    localparam int PW   = 2 * DW + 1;          // cross product component
    localparam int MW   = DW + PW;             // difference times cross component
    localparam int DETW = MW + 2;              // det, u, v
    localparam int CHW  = DETW / 3 + 1;        // chunk of u or v for the point multiply
    localparam int PPW  = CHW + 1 + DW;        // chunk partial product
    localparam int NW   = 3 * CHW + DW + 3;    // numerator u*e1 + v*e2
    localparam int RW   = DETW + C + 3;        // divider word
    localparam int QB   = C + 1;               // quotient bits
    localparam int RSW  = C + 3;               // point before clamping
    localparam int NST  = 12;                  // stages ahead of the divider
    localparam int WB   = sti_pkg::WORD_BITS;

    localparam logic signed [RSW-1:0] CMAX = RSW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [RSW-1:0] CMIN = -CMAX - RSW'(1);

    typedef struct packed {
        logic [2:0][C-1:0]  a;
        logic [C-1:0]       sy;
        logic [C-1:0]       ey;
        logic [2:0][DW-1:0] e1;
        logic [2:0][DW-1:0] e2;
    } side_t;

    typedef struct packed {
        logic [2:0]        neg;
        logic              cand;
        logic [2:0][C-1:0] a;
        logic [C-1:0]      sy;
        logic [C-1:0]      ey;
    } dside_t;

    function automatic logic signed [C-1:0] crd(input logic [WB-1:0] w, input int i);
        return w[i*C +: C];
    endfunction

    // global advance: hold everything while a finished item waits
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // configuration
    logic [sti_pkg::THR_BITS-1:0] thr_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= sti_pkg::THR_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= det_threshold;
    end

    // stage 1 inputs: unpack and take differences
    side_t              side_in;
    logic [2:0][DW-1:0] dir_in;
    logic [2:0][DW-1:0] tv_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            side_in.a[i]  = crd(vert_a, i);
            side_in.e1[i] = DW'(crd(vert_b, i)) - DW'(crd(vert_a, i));
            side_in.e2[i] = DW'(crd(vert_c, i)) - DW'(crd(vert_a, i));
            dir_in[i]     = DW'(crd(seg_end, i)) - DW'(crd(seg_start, i));
            tv_in[i]      = DW'(crd(seg_start, i)) - DW'(crd(vert_a, i));
        end
        side_in.sy = crd(seg_start, 1);
        side_in.ey = crd(seg_end, 1);
    end

    // pipeline registers
    logic [NST:1]        valid_reg;
    side_t               side_reg [1:NST];
    logic [2:0][DW-1:0]  dir_reg  [1:3];
    logic [2:0][DW-1:0]  tv_reg   [1:3];
    logic signed [2*DW-1:0] pvp_reg [6];
    logic signed [2*DW-1:0] qvp_reg [6];
    logic signed [PW-1:0]   pv_reg  [3];
    logic signed [PW-1:0]   qv_reg  [3];
    logic signed [MW-1:0]   dp_reg  [3];
    logic signed [MW-1:0]   up_reg  [3];
    logic signed [MW-1:0]   vq_reg  [3];
    logic [DETW-1:0]        det_reg;
    logic [DETW-1:0]        u0_reg;
    logic [DETW-1:0]        v0_reg;
    logic [DETW-1:0]        uf_reg;
    logic [DETW-1:0]        vf_reg;
    logic [DETW-1:0]        detf_reg [6:NST];
    logic                   cand_reg [7:NST];
    logic [DETW-1:0]        u7_reg;
    logic [DETW-1:0]        v7_reg;
    logic signed [PPW-1:0]  mu_reg [3][3];
    logic signed [PPW-1:0]  mv_reg [3][3];
    logic signed [NW-1:0]   su_reg [3];
    logic signed [NW-1:0]   sv_reg [3];
    logic signed [NW-1:0]   n_reg  [3];
    logic [2:0]             neg11_reg;
    logic [2:0]             neg12_reg;
    logic [RW-1:0]          mag_reg [3];
    logic [RW-1:0]          num_reg [3];
    logic [RW-1:0]          den_reg;

    logic                   pos6;
    logic                   cand7_next;
    logic [3*CHW-1:0]       upad;
    logic [3*CHW-1:0]       vpad;
    logic signed [NW-1:0]   nabs [3];

    assign pos6 = !det_reg[DETW-1] && (det_reg != '0);
    assign upad = {{(3*CHW-DETW){1'b0}}, u7_reg};
    assign vpad = {{(3*CHW-DETW){1'b0}}, v7_reg};

    // fold checks: nonzero det over threshold, barycentric bounds
    always_comb
    begin
        cand7_next = (detf_reg[6] != '0)
                  && (detf_reg[6] >= DETW'(thr_reg))
                  && !uf_reg[DETW-1] && (uf_reg <= detf_reg[6])
                  && !vf_reg[DETW-1]
                  && (({1'b0, uf_reg} + {1'b0, vf_reg}) <= {1'b0, detf_reg[6]});
        for (int i = 0; i < 3; i++)
            nabs[i] = n_reg[i][NW-1] ? -n_reg[i] : n_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NST-1:1], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= side_in;
            for (int k = 2; k <= NST; k++)
                side_reg[k] <= side_reg[k-1];
            dir_reg[1] <= dir_in;
            tv_reg[1]  <= tv_in;
            for (int k = 2; k <= 3; k++)
            begin
                dir_reg[k] <= dir_reg[k-1];
                tv_reg[k]  <= tv_reg[k-1];
            end

            // stage 2: cross product terms of dir x e2 and tv x e1
            pvp_reg[0] <= $signed(dir_reg[1][1]) * $signed(side_reg[1].e2[2]);
            pvp_reg[1] <= $signed(dir_reg[1][2]) * $signed(side_reg[1].e2[1]);
            pvp_reg[2] <= $signed(dir_reg[1][2]) * $signed(side_reg[1].e2[0]);
            pvp_reg[3] <= $signed(dir_reg[1][0]) * $signed(side_reg[1].e2[2]);
            pvp_reg[4] <= $signed(dir_reg[1][0]) * $signed(side_reg[1].e2[1]);
            pvp_reg[5] <= $signed(dir_reg[1][1]) * $signed(side_reg[1].e2[0]);
            qvp_reg[0] <= $signed(tv_reg[1][1]) * $signed(side_reg[1].e1[2]);
            qvp_reg[1] <= $signed(tv_reg[1][2]) * $signed(side_reg[1].e1[1]);
            qvp_reg[2] <= $signed(tv_reg[1][2]) * $signed(side_reg[1].e1[0]);
            qvp_reg[3] <= $signed(tv_reg[1][0]) * $signed(side_reg[1].e1[2]);
            qvp_reg[4] <= $signed(tv_reg[1][0]) * $signed(side_reg[1].e1[1]);
            qvp_reg[5] <= $signed(tv_reg[1][1]) * $signed(side_reg[1].e1[0]);

            for (int i = 0; i < 3; i++)
            begin
                // stage 3: cross products
                pv_reg[i] <= PW'(pvp_reg[2*i]) - PW'(pvp_reg[2*i+1]);
                qv_reg[i] <= PW'(qvp_reg[2*i]) - PW'(qvp_reg[2*i+1]);
                // stage 4: dot product terms
                dp_reg[i] <= $signed(side_reg[3].e1[i]) * pv_reg[i];
                up_reg[i] <= $signed(tv_reg[3][i]) * pv_reg[i];
                vq_reg[i] <= $signed(dir_reg[3][i]) * qv_reg[i];
            end

            // stage 5: det, u and v with tvec taken as start - A
            det_reg <= DETW'(dp_reg[0]) + DETW'(dp_reg[1]) + DETW'(dp_reg[2]);
            u0_reg  <= DETW'(up_reg[0]) + DETW'(up_reg[1]) + DETW'(up_reg[2]);
            v0_reg  <= DETW'(vq_reg[0]) + DETW'(vq_reg[1]) + DETW'(vq_reg[2]);

            // stage 6: sign fold; flipping tvec flips u and v
            detf_reg[6] <= pos6 ? det_reg : -det_reg;
            uf_reg      <= pos6 ? u0_reg  : -u0_reg;
            vf_reg      <= pos6 ? v0_reg  : -v0_reg;

            // stage 7: accept tests
            cand_reg[7] <= cand7_next;
            detf_reg[7] <= detf_reg[6];
            u7_reg      <= uf_reg;
            v7_reg      <= vf_reg;

            for (int k = 8; k <= NST; k++)
            begin
                cand_reg[k] <= cand_reg[k-1];
                detf_reg[k] <= detf_reg[k-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                // stage 8: chunked partial products of u*e1 and v*e2
                for (int j = 0; j < 3; j++)
                begin
                    mu_reg[i][j] <= $signed({1'b0, upad[j*CHW +: CHW]})
                                  * $signed(side_reg[7].e1[i]);
                    mv_reg[i][j] <= $signed({1'b0, vpad[j*CHW +: CHW]})
                                  * $signed(side_reg[7].e2[i]);
                end
                // stage 9: recombine chunks
                su_reg[i] <= NW'(mu_reg[i][0]) + (NW'(mu_reg[i][1]) <<< CHW)
                           + (NW'(mu_reg[i][2]) <<< (2 * CHW));
                sv_reg[i] <= NW'(mv_reg[i][0]) + (NW'(mv_reg[i][1]) <<< CHW)
                           + (NW'(mv_reg[i][2]) <<< (2 * CHW));
                // stage 10: numerator
                n_reg[i] <= su_reg[i] + sv_reg[i];
                // stage 11: magnitude and sign
                neg11_reg[i] <= n_reg[i][NW-1];
                mag_reg[i]   <= nabs[i][RW-1:0];
                // stage 12: round to nearest as (2|n| + det) / (2 det)
                num_reg[i]   <= {mag_reg[i][RW-2:0], 1'b0} + RW'(detf_reg[11]);
            end
            neg12_reg <= neg11_reg;
            den_reg   <= RW'({detf_reg[11], 1'b0});
        end
    end

    // divider, one per coordinate
    logic [QB-1:0] quo [3];

    for (genvar g = 0; g < 3; g++) begin : g_div
        sti_div #(
            .RW (RW),
            .QB (QB)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[g]),
            .den (den_reg),
            .quo (quo[g])
        );
    end

    // side data riding along the divider
    dside_t        dside_in;
    dside_t        dside_reg [QB];
    logic [QB-1:0] dvalid_reg;

    always_comb
    begin
        dside_in.neg  = neg12_reg;
        dside_in.cand = cand_reg[NST];
        dside_in.a    = side_reg[NST].a;
        dside_in.sy   = side_reg[NST].sy;
        dside_in.ey   = side_reg[NST].ey;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvalid_reg <= '0;
        else if (en)
            dvalid_reg <= {dvalid_reg[QB-2:0], valid_reg[NST]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside_reg[0] <= dside_in;
            for (int k = 1; k < QB; k++)
                dside_reg[k] <= dside_reg[k-1];
        end
    end

    // final: offset from A, clamp, y range test, pack
    logic signed [RSW-1:0] r_sum [3];
    logic signed [RSW-1:0] r_clp [3];
    logic signed [QB:0]    off   [3];
    logic signed [RSW-1:0] ys;
    logic signed [RSW-1:0] ye;
    logic                  y_ok;
    logic                  hit_next;
    logic [WB-1:0]         hit_point_next;
    logic                  hit_reg;
    logic [WB-1:0]         hit_point_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            off[i]   = dside_reg[QB-1].neg[i] ? -$signed({1'b0, quo[i]})
                                              :  $signed({1'b0, quo[i]});
            r_sum[i] = RSW'($signed(dside_reg[QB-1].a[i])) + RSW'(off[i]);
            if (r_sum[i] > CMAX)
                r_clp[i] = CMAX;
            else if (r_sum[i] < CMIN)
                r_clp[i] = CMIN;
            else
                r_clp[i] = r_sum[i];
        end
        ys   = RSW'($signed(dside_reg[QB-1].sy));
        ye   = RSW'($signed(dside_reg[QB-1].ey));
        y_ok = ((r_clp[1] >= ys) && (r_clp[1] <= ye))
            || ((r_clp[1] <= ys) && (r_clp[1] >= ye));
        hit_next = dside_reg[QB-1].cand && y_ok;
        if (hit_next)
            hit_point_next = WB'({r_clp[2][C-1:0], r_clp[1][C-1:0], r_clp[0][C-1:0]});
        else
            hit_point_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dvalid_reg[QB-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg       <= hit_next;
            hit_point_reg <= hit_point_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_point = hit_point_reg;

    // a delivered miss carries a zero point
    `ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !hit, hit_point == '0, "miss with nonzero point")
    // a stall freezes the whole pipeline
    `ASSERT_NEXT(a_hold, clk, rst_n, in_stall, $stable(valid_reg) && $stable(dvalid_reg), "pipeline moved during stall")
    // an accepted candidate never has a zero folded determinant
    `ASSERT_NOW(a_det_nz, clk, rst_n, valid_reg[NST] && cand_reg[NST], detf_reg[NST] != '0, "candidate with zero det")

endmodule
